[rtl/sia_pkg.sv]
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, codes and sizes for the spectrum insert and accumulate core.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int MAX_DIM_DEF     = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int DIM_W        = CFG_W;
  localparam int POS_W        = 6;
  localparam int COEF_W       = 32;
  localparam int MODE_W       = 2;
  localparam int FINE_INDEX_W = 18;
  localparam int STATUS_W     = 2;
  localparam int S_TDATA_W    = 88;
  localparam int M_TDATA_W    = 88;

  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 2;

  localparam logic [CFG_W-1:0] FINE_RST   = 7'd64;
  localparam logic [CFG_W-1:0] COARSE_RST = 7'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINE_X,
    REG_FINE_Y,
    REG_FINE_Z,
    REG_COARSE_X,
    REG_COARSE_Y,
    REG_COARSE_Z
  } reg_idx_t;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [COEF_W-1:0] value_im;
    logic signed [COEF_W-1:0] value_re;
    logic [FINE_INDEX_W-1:0]  fine_index;
  } result_t;

  // Entries per accumulator plane for a given largest grid size
  function automatic int acc_depth(input int dim);
    return dim * dim * ((dim >> 1) + 1);
  endfunction

endpackage

[rtl/sia_ram.sv]
// ----------------------------------------------------------------------------
// sia_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sia_queue.sv]
// ----------------------------------------------------------------------------
// sia_queue
// Small register FIFO used between front and back and ahead of the output.
// ----------------------------------------------------------------------------
module sia_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/sia_front.sv]
// ----------------------------------------------------------------------------
// sia_front
// Configuration registers, coordinate checks and coarse-to-fine mapping, and
// the two multiply stages that form the linear fine-grid address.
// ----------------------------------------------------------------------------
module sia_front #(
  parameter int MAX_DIM = sia_pkg::MAX_DIM_DEF,
  parameter int ADDR_W  = 18
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sia_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sia_pkg::CFG_W-1:0]      cfg_data,
  // incoming items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sia_pkg::MODE_W-1:0]     mode,
  input  logic [sia_pkg::POS_W-1:0]      pos_x,
  input  logic [sia_pkg::POS_W-1:0]      pos_y,
  input  logic [sia_pkg::POS_W-1:0]      pos_z,
  input  logic signed [sia_pkg::COEF_W-1:0] coef_re,
  input  logic signed [sia_pkg::COEF_W-1:0] coef_im,
  input  logic                           clearing,
  // classified items towards the queue
  output logic                           out_valid,
  input  logic                           out_ready,
  output sia_pkg::item_t                 out_item,
  output logic [ADDR_W-1:0]              out_idx
);

  import sia_pkg::*;

  localparam int EXT_W  = CFG_W + 1;
  localparam int ROW_W  = 2 * DIM_W;
  localparam int PROD_W = ROW_W + DIM_W;

  logic [CFG_W-1:0] fine_x, fine_y, fine_z;
  logic [CFG_W-1:0] coarse_x, coarse_y, coarse_z;
  logic [DIM_W-1:0] nx, ny, nz, cx, cy, cz;
  logic [DIM_W-1:0] nx2, cx2;

  logic             adv;
  logic             in_acc;

  // classification
  logic [DIM_W:0]   map_y, map_z;
  logic [DIM_W-1:0] px, py, pz;
  logic [DIM_W-1:0] fy_c, fz_c;
  op_t              op_c;

  // stage registers
  logic             v1, v2, v3;
  op_t              s1_op, s2_op;
  logic [DIM_W-1:0] s1_fx, s1_fy, s1_fz, s2_fx;
  logic [ROW_W-1:0] s2_row;
  item_t            s1_item, s2_item, s3_item;
  logic [ADDR_W-1:0] s3_idx;
  logic [PROD_W-1:0] prod;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? CFG_W'(MAX_DIM) : v;
  endfunction

  // Coarse y or z index to fine; top bit set when it lands inside the grid
  function automatic logic [DIM_W:0] map_axis(input logic [POS_W-1:0] c,
                                               input logic [CFG_W-1:0] cs,
                                               input logic [CFG_W-1:0] fs);
    logic [EXT_W-1:0] c_w;
    logic [EXT_W-1:0] half;
    logic [EXT_W-1:0] hi_sum;
    logic [EXT_W-1:0] f;
    logic             ok;
    c_w    = EXT_W'(c);
    half   = EXT_W'(cs >> 1) + 1'b1;
    hi_sum = EXT_W'(fs) + c_w;
    ok     = c_w < EXT_W'(cs);
    if (c_w < half) begin
      f = c_w;
    end else begin
      ok = ok && (hi_sum >= EXT_W'(cs));
      f  = hi_sum - EXT_W'(cs);
    end
    ok = ok && (f < EXT_W'(fs));
    return {ok, f[DIM_W-1:0]};
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_x   <= FINE_RST;
      fine_y   <= FINE_RST;
      fine_z   <= FINE_RST;
      coarse_x <= COARSE_RST;
      coarse_y <= COARSE_RST;
      coarse_z <= COARSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FINE_X:   fine_x   <= cfg_data;
        REG_FINE_Y:   fine_y   <= cfg_data;
        REG_FINE_Z:   fine_z   <= cfg_data;
        REG_COARSE_X: coarse_x <= cfg_data;
        REG_COARSE_Y: coarse_y <= cfg_data;
        REG_COARSE_Z: coarse_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nx  = clamp_dim(fine_x);
  assign ny  = clamp_dim(fine_y);
  assign nz  = clamp_dim(fine_z);
  assign cx  = clamp_dim(coarse_x);
  assign cy  = clamp_dim(coarse_y);
  assign cz  = clamp_dim(coarse_z);
  assign nx2 = (nx >> 1) + 1'b1;
  assign cx2 = (cx >> 1) + 1'b1;

  assign adv      = !v3 || out_ready;
  assign in_ready = adv && !clearing;
  assign in_acc   = in_valid && in_ready;

  assign px    = DIM_W'(pos_x);
  assign py    = DIM_W'(pos_y);
  assign pz    = DIM_W'(pos_z);
  assign map_y = map_axis(pos_y, cy, ny);
  assign map_z = map_axis(pos_z, cz, nz);

  always_comb begin
    op_c = OP_BAD;
    fy_c = py;
    fz_c = pz;
    unique case (mode) inside
      MODE_ADD: begin
        fy_c = map_y[DIM_W-1:0];
        fz_c = map_z[DIM_W-1:0];
        if (px < cx2 && px < nx2 && map_y[DIM_W] && map_z[DIM_W]) begin
          op_c = OP_ADD;
        end
      end
      MODE_READ, MODE_CLEAR: begin
        if (px < nx2 && py < ny && pz < nz) begin
          op_c = (mode == MODE_READ) ? OP_READ : OP_CLEAR;
        end
      end
      default: op_c = OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign prod = PROD_W'(s2_row) * PROD_W'(nx2) + PROD_W'(s2_fx);

  always_ff @(posedge clk) begin
    if (adv) begin
      // classify
      s1_op           <= op_c;
      s1_fx           <= px;
      s1_fy           <= fy_c;
      s1_fz           <= fz_c;
      s1_item.op      <= op_c;
      s1_item.coef_re <= coef_re;
      s1_item.coef_im <= coef_im;
      // row = z * ny + y
      s2_op           <= s1_op;
      s2_fx           <= s1_fx;
      s2_row          <= ROW_W'(s1_fz) * ROW_W'(ny) + ROW_W'(s1_fy);
      s2_item         <= s1_item;
      // index = row * (nx/2 + 1) + x
      s3_idx          <= (s2_op == OP_BAD) ? '0 : ADDR_W'(prod);
      s3_item         <= s2_item;
    end
  end

  assign out_valid = v3;
  assign out_item  = s3_item;
  assign out_idx   = s3_idx;

endmodule

[rtl/sia_back.sv]
// ----------------------------------------------------------------------------
// sia_back
// Accumulator planes with read-modify-write, one-beat write forwarding,
// saturation, result formatting and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module sia_back #(
  parameter int MAX_DIM     = sia_pkg::MAX_DIM_DEF,
  parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF,
  parameter int ADDR_W      = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sia_pkg::item_t    q_item,
  input  logic [ADDR_W-1:0] q_idx,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output sia_pkg::result_t  res,
  output logic              clearing
);

  import sia_pkg::*;

  localparam int ACC_DEPTH = acc_depth(MAX_DIM);
  localparam int EXT_W     = (VALUE_WIDTH > COEF_W) ? VALUE_WIDTH : COEF_W;
  localparam int SUM_W     = EXT_W + 1;
  localparam logic signed [SUM_W-1:0] VMAX =
    {{(SUM_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN =
    {{(SUM_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

  logic                          e_adv;
  logic                          e_valid;
  item_t                         e_item;
  logic [ADDR_W-1:0]             e_idx;
  logic [ADDR_W-1:0]             rd_addr;

  logic [VALUE_WIDTH-1:0]        ram_re, ram_im;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [VALUE_WIDTH-1:0]        wr_re, wr_im;

  logic                          item_wr;
  logic [VALUE_WIDTH-1:0]        item_re, item_im;

  logic                          fwd_we;
  logic [ADDR_W-1:0]             fwd_addr;
  logic [VALUE_WIDTH-1:0]        fwd_re, fwd_im;
  logic                          fwd_hit;

  logic signed [VALUE_WIDTH-1:0] old_re, old_im;
  logic [VALUE_WIDTH:0]          add_re, add_im;

  logic [ADDR_W-1:0]             clr_addr;

  // {saturated, clamped sum}
  function automatic logic [VALUE_WIDTH:0] sat_add(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [COEF_W-1:0]      b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > VMAX) begin
      return {1'b1, VMAX[VALUE_WIDTH-1:0]};
    end else if (s < VMIN) begin
      return {1'b1, VMIN[VALUE_WIDTH-1:0]};
    end
    return {1'b0, s[VALUE_WIDTH-1:0]};
  endfunction

  function automatic logic [COEF_W-1:0] to_out(input logic signed [VALUE_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] x;
    x = EXT_W'(v);
    return x[COEF_W-1:0];
  endfunction

  assign e_adv = !e_valid || !res_full;
  assign q_pop = e_adv && q_valid && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_adv) begin
      e_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      e_item <= q_item;
      e_idx  <= q_idx;
    end
  end

  // Read for whichever item sits in the execute stage next cycle
  assign rd_addr = e_adv ? q_idx : e_idx;

  sia_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ACC_DEPTH)
  ) u_ram_re (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_re),
    .raddr (rd_addr),
    .rdata (ram_re)
  );

  sia_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ACC_DEPTH)
  ) u_ram_im (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_im),
    .raddr (rd_addr),
    .rdata (ram_im)
  );

  // The write of the previous beat is missing from the read data
  assign fwd_hit = fwd_we && (fwd_addr == e_idx);
  assign old_re  = fwd_hit ? fwd_re : ram_re;
  assign old_im  = fwd_hit ? fwd_im : ram_im;
  assign add_re  = sat_add(old_re, e_item.coef_re);
  assign add_im  = sat_add(old_im, e_item.coef_im);

  assign item_wr  = e_valid && e_adv && (e_item.op == OP_ADD || e_item.op == OP_CLEAR);
  assign item_re  = (e_item.op == OP_ADD) ? add_re[VALUE_WIDTH-1:0] : '0;
  assign item_im  = (e_item.op == OP_ADD) ? add_im[VALUE_WIDTH-1:0] : '0;

  assign wr_en   = clearing || item_wr;
  assign wr_addr = clearing ? clr_addr : e_idx;
  assign wr_re   = clearing ? '0 : item_re;
  assign wr_im   = clearing ? '0 : item_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_we <= 1'b0;
    end else begin
      fwd_we <= item_wr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= e_idx;
    fwd_re   <= item_re;
    fwd_im   <= item_im;
  end

  // Zero both planes, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(ACC_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign res_push = e_valid && e_adv;

  always_comb begin
    res.fine_index = FINE_INDEX_W'(e_idx);
    res.value_re   = '0;
    res.value_im   = '0;
    res.status     = STATUS_OK;
    unique case (e_item.op)
      OP_ADD: begin
        res.value_re = to_out(add_re[VALUE_WIDTH-1:0]);
        res.value_im = to_out(add_im[VALUE_WIDTH-1:0]);
        res.status   = (add_re[VALUE_WIDTH] || add_im[VALUE_WIDTH]) ? STATUS_SAT : STATUS_OK;
      end
      OP_READ: begin
        res.value_re = to_out(old_re);
        res.value_im = to_out(old_im);
      end
      OP_CLEAR: ;
      default: begin
        res.fine_index = '0;
        res.status     = STATUS_RANGE;
      end
    endcase
  end

endmodule

[rtl/spectrum_insert_accumulate_core.sv]
// ----------------------------------------------------------------------------
// spectrum_insert_accumulate_core
// Fine-grid half-complex spectrum accumulator fed with coarse coefficients.
// ----------------------------------------------------------------------------
//  channel  | side   | handshake            | contents
//  ---------+--------+----------------------+---------------------------------
//  s_axis   | in     | tvalid / tready      | tuser mode; tdata coordinates,
//           |        |                      | coefficient
//  m_axis   | out    | tvalid / tready      | tuser status; tdata fine index,
//           |        |                      | entry value
//  cfg      | in     | cfg_valid / cfg_ready| cfg_index, cfg_data (size regs)
//
//  One item per clock sustained while m_axis is ready; each plane RAM does
//  one read and at most one write per beat, the previous beat's write
//  forwarded into the add. Items pass the classify, row and index stages,
//  middle queue, execute stage and output queue. After reset s_axis_tready
//  stays low while all MAX_DIM*MAX_DIM*(MAX_DIM/2+1) entries of both planes
//  (135168 at defaults) are zeroed; cfg writes are taken throughout. A stalled
//  m_axis fills the output and middle queues before s_axis_tready drops.
// ----------------------------------------------------------------------------
module spectrum_insert_accumulate_core #(
  parameter int MAX_DIM     = sia_pkg::MAX_DIM_DEF,
  parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pos_z, coef_re, coef_im
  input  logic [sia_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [sia_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fine_index, value_re, value_im
  output logic [sia_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [sia_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sia_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sia_pkg::CFG_W-1:0]       cfg_data
);

  import sia_pkg::*;

  localparam int ADDR_W  = $clog2(acc_depth(MAX_DIM));
  localparam int Q_W     = $bits(item_t) + ADDR_W;
  localparam int M_PAD_W = M_TDATA_W - (FINE_INDEX_W + 2 * COEF_W);

  logic              f_valid;
  item_t             f_item;
  logic [ADDR_W-1:0] f_idx;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [Q_W-1:0]    q_dout;
  item_t             q_item;
  logic [ADDR_W-1:0] q_idx;
  logic              clearing;
  logic              res_push;
  result_t           res;
  logic              o_full;
  result_t           o_res;

  sia_front #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mode      (s_axis_tuser),
    .pos_x     (s_axis_tdata[POS_W-1:0]),
    .pos_y     (s_axis_tdata[2*POS_W-1:POS_W]),
    .pos_z     (s_axis_tdata[3*POS_W-1:2*POS_W]),
    .coef_re   ($signed(s_axis_tdata[3*POS_W+COEF_W-1:3*POS_W])),
    .coef_im   ($signed(s_axis_tdata[3*POS_W+2*COEF_W-1:3*POS_W+COEF_W])),
    .clearing  (clearing),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_item  (f_item),
    .out_idx   (f_idx)
  );

  sia_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   ({f_idx, f_item}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  assign {q_idx, q_item} = q_dout;

  sia_back #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_idx    (q_idx),
    .q_pop    (q_pop),
    .res_full (o_full),
    .res_push (res_push),
    .res      (res),
    .clearing (clearing)
  );

  sia_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (o_full),
    .pop   (m_axis_tready),
    .dout  (o_res),
    .valid (m_axis_tvalid)
  );

  assign m_axis_tdata = {{M_PAD_W{1'b0}}, o_res.value_im, o_res.value_re, o_res.fine_index};
  assign m_axis_tuser = o_res.status;

endmodule

[rtl/sia_checker.sv]
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks for the spectrum insert and accumulate core.
// ----------------------------------------------------------------------------
module sia_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sia_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [sia_pkg::MODE_W-1:0]    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sia_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sia_pkg::STATUS_W-1:0]  m_axis_tuser,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [sia_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [sia_pkg::CFG_W-1:0]     cfg_data
);

  import sia_pkg::*;

  localparam int FIELDS_W = FINE_INDEX_W + 2 * COEF_W;

  logic       s_beat;
  logic       m_beat;
  logic [4:0] pending;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // items accepted whose result has not yet left
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({s_beat, m_beat})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    m_beat |-> pending != '0)
    else $error("result beat with no item outstanding");

  a_range_zeroes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STATUS_RANGE) |-> m_axis_tdata[FIELDS_W-1:0] == '0)
    else $error("out-of-range result carries non-zero fields");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("input taken before the clearing sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind spectrum_insert_accumulate_core sia_checker u_sia_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the spectrum insert and accumulate core. The test
// keeps its own copy of both accumulator planes and the six grid-size
// registers, works out the result of every accepted beat and compares it
// field by field with what leaves m_axis. Directed beats cover the corner
// cases; random beats run over several grid settings with random gaps on
// both sides, one gap-free stretch and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import sia_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int ACC_DEPTH    = MAX_DIM_DEF * MAX_DIM_DEF * (MAX_DIM_DEF / 2 + 1);
  localparam int IDLE_PCT     = 33;
  localparam int DRAIN_GAP    = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int VAL_MAX      = 32'sh7fffffff;
  localparam int VAL_MIN      = 32'sh80000000;

  localparam logic [MODE_W-1:0]    MODE_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = MODE_ADD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  spectrum_insert_accumulate_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Mirror of the accumulator planes and the grid registers
  int          acc_re [ACC_DEPTH];
  int          acc_im [ACC_DEPTH];
  logic [CFG_W-1:0] grid_reg [6] = '{FINE_RST, FINE_RST, FINE_RST,
                                     COARSE_RST, COARSE_RST, COARSE_RST};
  result_t     pending_results [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_ask = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  result_t     want;
  result_t     got;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int grid_size(reg_idx_t k);
    return (grid_reg[k] > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(grid_reg[k]);
  endfunction

  // Coarse y or z index to fine; negative frequencies go to the top
  function automatic bit map_to_fine(int c, int csize, int fsize, output int f);
    f = 0;
    if (c >= csize) return 1'b0;
    if (c < csize / 2 + 1) begin
      f = c;
    end else begin
      if (fsize + c < csize) return 1'b0;
      f = fsize + c - csize;
    end
    return f < fsize;
  endfunction

  function automatic int clamp_sum(longint s, inout bit hit);
    if (s > VAL_MAX) begin
      hit = 1'b1;
      return VAL_MAX;
    end
    if (s < VAL_MIN) begin
      hit = 1'b1;
      return VAL_MIN;
    end
    return int'(s);
  endfunction

  function automatic void accumulate_entry(input logic [MODE_W-1:0] mode,
                                           input int px, input int py, input int pz,
                                           input logic signed [COEF_W-1:0] re,
                                           input logic signed [COEF_W-1:0] im,
                                           output result_t r);
    int nx2, ny, nz, fx, fy, fz, idx;
    bit ok, hit;
    nx2 = grid_size(REG_FINE_X) / 2 + 1;
    ny  = grid_size(REG_FINE_Y);
    nz  = grid_size(REG_FINE_Z);
    fx  = px;
    fy  = py;
    fz  = pz;
    ok  = 1'b0;
    hit = 1'b0;
    r   = '0;
    if (mode == MODE_ADD) begin
      ok = px < grid_size(REG_COARSE_X) / 2 + 1 && px < nx2;
      if (!map_to_fine(py, grid_size(REG_COARSE_Y), ny, fy)) ok = 1'b0;
      if (!map_to_fine(pz, grid_size(REG_COARSE_Z), nz, fz)) ok = 1'b0;
    end else if (mode == MODE_READ || mode == MODE_CLEAR) begin
      ok = fx < nx2 && fy < ny && fz < nz;
    end
    if (!ok) begin
      r.status = STATUS_RANGE;
      return;
    end
    idx = (fz * ny + fy) * nx2 + fx;
    if (mode == MODE_ADD) begin
      acc_re[idx] = clamp_sum(longint'(acc_re[idx]) + longint'(re), hit);
      acc_im[idx] = clamp_sum(longint'(acc_im[idx]) + longint'(im), hit);
    end else if (mode == MODE_CLEAR) begin
      acc_re[idx] = 0;
      acc_im[idx] = 0;
    end
    r.fine_index = FINE_INDEX_W'(idx);
    r.value_re   = acc_re[idx];
    r.value_im   = acc_im[idx];
    r.status     = hit ? STATUS_SAT : STATUS_OK;
  endfunction

  function automatic int pick(int n);
    return (n <= 1) ? 0 : int'($urandom_range(0, n - 1));
  endfunction

  // Mostly modest values so entries build up; extremes force saturation
  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX - $urandom_range(0, 3);
      1:       return VAL_MIN + $urandom_range(0, 3);
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
    endcase
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] mode, input int px, input int py,
                           input int pz, input logic signed [COEF_W-1:0] re,
                           input logic signed [COEF_W-1:0] im);
    result_t r;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(S_TDATA_W - 3 * POS_W - 2 * COEF_W){1'b0}}, im, re,
                      POS_W'(pz), POS_W'(py), POS_W'(px)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accumulate_entry(mode, px, py, pz, re, im, r);
    pending_results = {pending_results, r};
  endtask

  task automatic send_random(input int count);
    int nx2, sel;
    for (int i = 0; i < count; i++) begin
      nx2 = grid_size(REG_FINE_X) / 2 + 1;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_beat(MODE_ADD,
                  pick((grid_size(REG_COARSE_X) / 2 + 1 < nx2) ?
                       grid_size(REG_COARSE_X) / 2 + 1 : nx2),
                  pick(grid_size(REG_COARSE_Y)), pick(grid_size(REG_COARSE_Z)),
                  rand_coef(), rand_coef());
      end else if (sel < 78) begin
        send_beat((sel < 70) ? MODE_READ : MODE_CLEAR, pick(nx2),
                  pick(grid_size(REG_FINE_Y)), pick(grid_size(REG_FINE_Z)),
                  rand_coef(), rand_coef());
      end else begin
        // Noise: any mode, any coordinate
        send_beat(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 63), rand_coef(), rand_coef());
      end
    end
  endtask

  // Drop valid and wait for every outstanding result, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index <= REG_COARSE_Z) grid_reg[index] = value;
  endtask

  task automatic set_grid(input int fx, input int fy, input int fz,
                          input int cx, input int cy, input int cz);
    write_reg(REG_FINE_X, CFG_W'(fx));
    write_reg(REG_FINE_Y, CFG_W'(fy));
    write_reg(REG_FINE_Z, CFG_W'(fz));
    write_reg(REG_COARSE_X, CFG_W'(cx));
    write_reg(REG_COARSE_Y, CFG_W'(cy));
    write_reg(REG_COARSE_Z, CFG_W'(cz));
    cfg_valid <= 1'b0;
  endtask

  // Reset sizes: fine 64, coarse 32, so coarse half-range ends at 16
  task automatic test_directed();
    send_beat(MODE_READ, 0, 0, 0, 0, 0);
    send_beat(MODE_ADD, 0, 0, 0, VAL_MAX, VAL_MIN);
    send_beat(MODE_ADD, 0, 0, 0, 1, -1);
    send_beat(MODE_ADD, 0, 0, 0, VAL_MIN, VAL_MAX);
    send_beat(MODE_CLEAR, 0, 0, 0, -1, -1);
    send_beat(MODE_READ, 0, 0, 0, 0, 0);
    send_beat(MODE_ADD, 16, 16, 16, 5, -5);
    send_beat(MODE_ADD, 16, 17, 31, 12345, -67890);
    send_beat(MODE_READ, 16, 49, 63, 0, 0);
    send_beat(MODE_ADD, 17, 0, 0, 1, 1);
    send_beat(MODE_ADD, 0, 32, 0, 1, 1);
    send_beat(MODE_ADD, 0, 0, 32, 1, 1);
    send_beat(MODE_READ, 32, 63, 63, 0, 0);
    send_beat(MODE_READ, 33, 0, 0, 0, 0);
    send_beat(MODE_CLEAR, 63, 63, 63, 0, 0);
    send_beat(MODE_UNUSED, 0, 0, 0, 7, 7);
    send_beat(MODE_ADD, 63, 63, 63, -1, -1);
    send_beat(MODE_ADD, 15, 31, 31, -1, 32'sh55555555);
    send_beat(MODE_ADD, 15, 31, 31, 32'shaaaaaaaa, 32'sh55555555);
    send_beat(MODE_READ, 15, 63, 63, 0, 0);
    send_beat(MODE_CLEAR, 16, 49, 63, 0, 0);
    send_beat(MODE_READ, 16, 49, 63, 0, 0);
    drain();
  endtask

  task automatic test_grid_extremes();
    write_reg(REG_SPARE_LO, 7'h7f);
    write_reg(REG_SPARE_HI, 7'h55);
    set_grid(4, 4, 4, 4, 4, 4);
    send_random(60);
    drain();
    // Above the largest size: treated as the largest
    set_grid(127, 100, 65, 64, 64, 64);
    send_random(60);
    drain();
    // Coarse grid larger than fine: coarse indices that map outside the fine grid fall off
    set_grid(8, 8, 8, 127, 64, 100);
    send_random(60);
    drain();
    set_grid(37, 23, 50, 13, 7, 21);
    send_random(60);
    drain();
    set_grid(3, 2, 1, 1, 0, 3);
    send_random(60);
    drain();
  endtask

  task automatic test_random_settings();
    int fx, fy, fz;
    for (int p = 0; p < 7; p++) begin
      fx = (p == 0) ? $urandom_range(4, 127) : $urandom_range(4, 16);
      fy = (p == 0) ? $urandom_range(4, 127) : $urandom_range(4, 16);
      fz = (p == 0) ? $urandom_range(4, 127) : $urandom_range(4, 16);
      set_grid(fx, fy, fz, $urandom_range(4, fx), $urandom_range(4, fy),
               $urandom_range(4, fz));
      send_random(200);
      drain();
    end
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    send_random(200);
    drain();
    no_idle = 1'b0;
  endtask

  // Stall the output for a long stretch while beats keep coming
  task automatic test_backpressure();
    no_idle   = 1'b1;
    hold_ask <= ~hold_ask;
    send_random(48);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_grid_extremes();
    test_random_settings();
    test_streaming();
    test_backpressure();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Output side: random stalls, a gap-free stretch and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen     <= hold_ask;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.fine_index = m_axis_tdata[FINE_INDEX_W-1:0];
      got.value_re   = m_axis_tdata[FINE_INDEX_W +: COEF_W];
      got.value_im   = m_axis_tdata[FINE_INDEX_W + COEF_W +: COEF_W];
      got.status     = m_axis_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got index %0d re %0d im %0d status %0d",
                 $time, got.fine_index, got.value_re, got.value_im, got.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.fine_index !== want.fine_index) begin
          $display("%0t: fine_index expected %0d got %0d", $time, want.fine_index,
                   got.fine_index);
          mismatches++;
        end
        if (got.value_re !== want.value_re) begin
          $display("%0t: value_re expected %0d got %0d", $time, want.value_re, got.value_re);
          mismatches++;
        end
        if (got.value_im !== want.value_im) begin
          $display("%0t: value_im expected %0d got %0d", $time, want.value_im, got.value_im);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  // Covers the clearing pass after reset with plenty to spare
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

endmodule
